/* rtl/pass_trajectory_generator_top_macros.svh */
// Assertion macros shared by the pass trajectory generator RTL.
// No dependencies; included by the files that carry assertions.
`ifndef PASS_TRAJECTORY_GENERATOR_TOP_MACROS_SVH
`define PASS_TRAJECTORY_GENERATOR_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
// Condition implies consequence in the same cycle.
`define PTG_ASSERT_IMPL(label, clk, rst_n, cond, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error("assertion failed");
// Condition implies consequence in the next cycle.
`define PTG_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error("assertion failed");
`else
`define PTG_ASSERT_IMPL(label, clk, rst_n, cond, cons)
`define PTG_ASSERT_NEXT(label, clk, rst_n, cond, cons)
`endif
`endif

/* rtl/ptg_pkg.sv */
// Shared constants, request types and the sin^2 table of the pass generator.
// No dependencies; imported by every module of the block.
package ptg_pkg;

  localparam int FRACTION_BITS = 16;
  localparam int TAB_BITS      = 6;
  localparam int SH            = FRACTION_BITS - TAB_BITS;
  localparam int TW            = FRACTION_BITS + 1;
  localparam int MW            = (TW > 17) ? TW : 17;
  localparam int PW            = 2 * MW;
  localparam int DW            = 16;

  localparam logic [TW-1:0] ONE_T  = TW'(1) << FRACTION_BITS;
  localparam logic [TW-1:0] HALF_T = TW'(1) << (FRACTION_BITS - 1);

  localparam logic [15:0] FULL_CIRCLE  = 16'd36000;
  localparam logic [13:0] MAX_PEAK     = 14'd9000;
  localparam logic [15:0] MIN_DURATION = 16'd10;
  localparam logic signed [14:0] EXPIRED_EL = -15'sd500;

  // Register indexes of the configuration port.
  localparam logic [2:0] REG_ENABLE   = 3'd0;
  localparam logic [2:0] REG_LOOP     = 3'd1;
  localparam logic [2:0] REG_AZ_START = 3'd2;
  localparam logic [2:0] REG_AZ_END   = 3'd3;
  localparam logic [2:0] REG_PEAK     = 3'd4;
  localparam logic [2:0] REG_DURATION = 3'd5;
  localparam logic [2:0] REG_HOLD     = 3'd6;

  typedef struct packed {
    logic          start;
    logic [MW-1:0] a;
    logic [MW-1:0] b;
  } ptg_mul_req_t;

  typedef struct packed {
    logic          start;
    logic [DW-1:0] num;
    logic [DW-1:0] den;
  } ptg_div_req_t;

  // sin^2(pi*t) in Q16 over t in [0, 1/2], 33 points.
  function automatic logic [16:0] sin2_tab(input logic [5:0] k);
    logic [16:0] v;
    case (k)
      6'd0:  v = 17'd0;     6'd1:  v = 17'd158;   6'd2:  v = 17'd630;
      6'd3:  v = 17'd1411;  6'd4:  v = 17'd2494;  6'd5:  v = 17'd3869;
      6'd6:  v = 17'd5522;  6'd7:  v = 17'd7438;  6'd8:  v = 17'd9598;
      6'd9:  v = 17'd11980; 6'd10: v = 17'd14563; 6'd11: v = 17'd17321;
      6'd12: v = 17'd20228; 6'd13: v = 17'd23256; 6'd14: v = 17'd26376;
      6'd15: v = 17'd29556; 6'd16: v = 17'd32768; 6'd17: v = 17'd35980;
      6'd18: v = 17'd39160; 6'd19: v = 17'd42280; 6'd20: v = 17'd45308;
      6'd21: v = 17'd48215; 6'd22: v = 17'd50973; 6'd23: v = 17'd53556;
      6'd24: v = 17'd55938; 6'd25: v = 17'd58098; 6'd26: v = 17'd60014;
      6'd27: v = 17'd61667; 6'd28: v = 17'd63042; 6'd29: v = 17'd64125;
      6'd30: v = 17'd64906; 6'd31: v = 17'd65378;
      default: v = 17'd65536;
    endcase
    return v;
  endfunction

endpackage

/* rtl/ptg_mul.sv */
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
// Depends on ptg_pkg for widths and the request type.
module ptg_mul import ptg_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  ptg_mul_req_t  req,
  output logic          done,
  output logic [PW-1:0] prod
);

  localparam int CW = $clog2(MW + 1);

  logic [MW-1:0] a_r;
  logic [MW-1:0] b_r;
  logic [PW-1:0] acc_r;
  logic [PW-1:0] acc_nxt;
  logic [CW-1:0] cnt_r;
  logic          done_r;

  // Next partial sum: shift left, add the multiplicand for a set bit.
  assign acc_nxt = {acc_r[PW-2:0], 1'b0} + (b_r[MW-1] ? {{(PW-MW){1'b0}}, a_r} : '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        a_r   <= req.a;
        b_r   <= req.b;
        acc_r <= '0;
        cnt_r <= CW'(MW);
      end else if (cnt_r != '0) begin
        acc_r <= acc_nxt;
        b_r   <= {b_r[MW-2:0], 1'b0};
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

/* rtl/ptg_div.sv */
// Restoring divider, one quotient bit per cycle; numerator below divisor.
// Depends on ptg_pkg for widths and the request type.
module ptg_div import ptg_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  ptg_div_req_t             req,
  output logic                     done,
  output logic [FRACTION_BITS-1:0] quot
);

  localparam int CW = $clog2(FRACTION_BITS + 1);

  logic [DW-1:0]            rem_r;
  logic [DW-1:0]            den_r;
  logic [FRACTION_BITS-1:0] q_r;
  logic [CW-1:0]            cnt_r;
  logic                     done_r;
  logic [DW:0]              sh;
  logic [DW:0]              sub;
  logic                     ge;

  // Shift the partial remainder in and try the subtraction.
  assign sh  = {rem_r, 1'b0};
  assign ge  = sh >= {1'b0, den_r};
  assign sub = sh - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        rem_r <= req.num;
        den_r <= req.den;
        q_r   <= '0;
        cnt_r <= CW'(FRACTION_BITS);
      end else if (cnt_r != '0) begin
        rem_r <= ge ? sub[DW-1:0] : sh[DW-1:0];
        q_r   <= {q_r[FRACTION_BITS-2:0], ge};
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

/* rtl/pass_trajectory_generator_top.sv */
// Top level of the pass trajectory generator: registers, sequencer, result.
// Depends on ptg_pkg, ptg_div, ptg_mul and the assertion macro header.
//
//   channel  direction  handshake          payload
//   in_      input      in_valid/in_stall  in_cmd, in_time_now
//   out_     output     out_valid/out_stall out_azimuth, out_elevation, out_valid_res
//   cfg_     input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// A moving-pass sample goes through a check state, the serial divider and three passes
// through the shared serial multiplier, then the result. From the duration up to the
// end of the hold the divider is skipped; start commands are taken in the idle state,
// disabled samples go straight to the result and expired ones through the check state.
// Reset is synchronous and active low; cfg_ready is always high.
// A stalled result holds the output register; the sequencer waits in its last
// state until that register is free.
`include "pass_trajectory_generator_top_macros.svh"
module pass_trajectory_generator_top import ptg_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_cmd,
  input  logic [31:0]        in_time_now,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        out_azimuth,
  output logic signed [14:0] out_elevation,
  output logic               out_valid_res,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE, S_CHECK, S_DIV, S_MUL_AZ, S_MUL_IP, S_MUL_EL, S_FINISH
  } state_t;

  state_t state_r;

  // Configuration registers.
  logic        enable_r, loop_r;
  logic [15:0] az_start_r, az_end_r, dur_r, hold_r;
  logic [13:0] peak_r;

  logic [31:0] start_time_r, now_r;
  logic        started_r;
  logic        past_r, neg_r;
  logic [14:0] mag_r;
  logic [TW-1:0] t_r;
  logic [16:0] base_r;
  logic [15:0] res_az_r;
  logic signed [14:0] res_el_r;
  logic        res_v_r;
  logic        out_valid_r, out_v_res_r;
  logic [15:0] out_az_r;
  logic signed [14:0] out_el_r;

  ptg_mul_req_t mul_req_r;
  ptg_div_req_t div_req_r;
  logic          mul_done, div_done;
  logic [PW-1:0] prod;
  logic [FRACTION_BITS-1:0] quot;

  ptg_mul u_mul (.clk(clk), .rst_n(rst_n), .req(mul_req_r), .done(mul_done), .prod(prod));
  ptg_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req_r), .done(div_done), .quot(quot));

  // Register values brought into range.
  logic [15:0] a0, a1, dur_c;
  logic [13:0] peak_c;
  logic [16:0] limit;
  assign a0     = (az_start_r >= FULL_CIRCLE) ? az_start_r - FULL_CIRCLE : az_start_r;
  assign a1     = (az_end_r >= FULL_CIRCLE) ? az_end_r - FULL_CIRCLE : az_end_r;
  assign peak_c = (peak_r > MAX_PEAK) ? MAX_PEAK : peak_r;
  assign dur_c  = (dur_r < MIN_DURATION) ? MIN_DURATION : dur_r;
  assign limit  = {1'b0, dur_c} + {1'b0, hold_r};

  // Elapsed time, clamped at zero, and its comparisons.
  logic [32:0] diff33;
  logic [31:0] dt;
  logic        dt_gt_lim, dt_ge_dur, dt_gt_dur;
  assign diff33    = {1'b0, now_r} - {1'b0, start_time_r};
  assign dt        = diff33[32] ? 32'd0 : diff33[31:0];
  assign dt_gt_lim = dt > {15'd0, limit};
  assign dt_ge_dur = dt >= {16'd0, dur_c};
  assign dt_gt_dur = dt > {16'd0, dur_c};

  // Shortest-arc difference between start and end azimuth.
  logic signed [16:0] d_raw, d;
  assign d_raw = $signed({1'b0, a1}) - $signed({1'b0, a0});
  always_comb begin
    if (d_raw > 17'sd18000) begin
      d = d_raw - 17'sd36000;
    end else if (d_raw < -17'sd18000) begin
      d = d_raw + 17'sd36000;
    end else begin
      d = d_raw;
    end
  end

  // Azimuth from the rounded offset product, wrapped into one circle.
  logic [PW:0]        az_round;
  logic [15:0]        p;
  logic signed [17:0] az_s;
  logic [15:0]        az_nxt;
  assign az_round = {1'b0, prod} + (PW+1)'(HALF_T);
  assign p        = 16'(az_round >> FRACTION_BITS);
  assign az_s     = neg_r ? $signed({2'b0, a0}) - $signed({2'b0, p})
                          : $signed({2'b0, a0}) + $signed({2'b0, p});
  always_comb begin
    if (az_s < 0) begin
      az_nxt = 16'(az_s + $signed(18'(FULL_CIRCLE)));
    end else if (az_s >= $signed(18'(FULL_CIRCLE))) begin
      az_nxt = 16'(az_s - $signed(18'(FULL_CIRCLE)));
    end else begin
      az_nxt = 16'(az_s);
    end
  end

  // Table lookup: fold t about one half, split into index and fraction.
  logic [TW-1:0] tf;
  logic [5:0]    k;
  logic [SH-1:0] frac;
  logic [16:0]   base_nxt, step_nxt, value_nxt;
  assign tf       = (t_r > HALF_T) ? ONE_T - t_r : t_r;
  assign k        = tf[FRACTION_BITS-1:SH];
  assign frac     = tf[SH-1:0];
  assign base_nxt = sin2_tab(k);
  assign step_nxt = (k[5]) ? 17'd0 : sin2_tab(6'(k + 6'd1)) - base_nxt;
  assign value_nxt = base_r + 17'(prod >> SH);

  // Elevation from the rounded peak product.
  logic [PW:0]        el_round;
  logic signed [14:0] el_nxt;
  assign el_round = {1'b0, prod} + (PW+1)'(32768);
  assign el_nxt   = $signed(15'(el_round >> 16));

  // Sequencer, configuration and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      enable_r     <= 1'b0;
      loop_r       <= 1'b0;
      az_start_r   <= 16'd0;
      az_end_r     <= 16'd18000;
      peak_r       <= 14'd4500;
      dur_r        <= 16'd120;
      hold_r       <= 16'd0;
      start_time_r <= 32'd0;
      started_r    <= 1'b0;
      out_valid_r  <= 1'b0;
      mul_req_r    <= '0;
      div_req_r    <= '0;
    end else begin
      mul_req_r.start <= 1'b0;
      div_req_r.start <= 1'b0;
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            if (in_cmd) begin
              start_time_r <= in_time_now;
              started_r    <= 1'b1;
            end else if (!enable_r) begin
              res_az_r <= 16'd0;
              res_el_r <= '0;
              res_v_r  <= 1'b0;
              state_r  <= S_FINISH;
            end else begin
              if (!started_r) begin
                start_time_r <= in_time_now;
                started_r    <= 1'b1;
              end
              now_r   <= in_time_now;
              state_r <= S_CHECK;
            end
          end
        end
        S_CHECK: begin
          neg_r <= d < 0;
          mag_r <= 15'(d < 0 ? -d : d);
          if (dt_gt_lim && !loop_r) begin
            res_az_r <= a1;
            res_el_r <= EXPIRED_EL;
            res_v_r  <= 1'b0;
            state_r  <= S_FINISH;
          end else if (!dt_gt_lim && dt_ge_dur) begin
            past_r          <= dt_gt_dur;
            t_r             <= ONE_T;
            mul_req_r.start <= 1'b1;
            mul_req_r.a     <= MW'(d < 0 ? -d : d);
            mul_req_r.b     <= MW'(ONE_T);
            state_r         <= S_MUL_AZ;
          end else begin
            if (dt_gt_lim) begin
              start_time_r <= now_r;
            end
            past_r          <= 1'b0;
            div_req_r.start <= 1'b1;
            div_req_r.num   <= dt_gt_lim ? 16'd0 : dt[15:0];
            div_req_r.den   <= dur_c;
            state_r         <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            t_r             <= {1'b0, quot};
            mul_req_r.start <= 1'b1;
            mul_req_r.a     <= MW'(mag_r);
            mul_req_r.b     <= MW'({1'b0, quot});
            state_r         <= S_MUL_AZ;
          end
        end
        S_MUL_AZ: begin
          if (mul_done) begin
            res_az_r        <= az_nxt;
            base_r          <= base_nxt;
            mul_req_r.start <= 1'b1;
            mul_req_r.a     <= MW'(step_nxt);
            mul_req_r.b     <= MW'(frac);
            state_r         <= S_MUL_IP;
          end
        end
        S_MUL_IP: begin
          if (mul_done) begin
            mul_req_r.start <= 1'b1;
            mul_req_r.a     <= MW'(peak_c);
            mul_req_r.b     <= MW'(value_nxt);
            state_r         <= S_MUL_EL;
          end
        end
        S_MUL_EL: begin
          if (mul_done) begin
            res_v_r <= 1'b1;
            if (past_r) begin
              res_az_r <= a1;
              res_el_r <= '0;
            end else begin
              res_el_r <= el_nxt;
            end
            state_r <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            out_az_r    <= res_az_r;
            out_el_r    <= res_el_r;
            out_v_res_r <= res_v_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
      // Register writes; clearing enable also clears the started flag.
      if (cfg_valid) begin
        case (cfg_index)
          REG_ENABLE: begin
            enable_r <= cfg_data[0];
            if (!cfg_data[0]) begin
              started_r <= 1'b0;
            end
          end
          REG_LOOP:     loop_r     <= cfg_data[0];
          REG_AZ_START: az_start_r <= cfg_data;
          REG_AZ_END:   az_end_r   <= cfg_data;
          REG_PEAK:     peak_r     <= cfg_data[13:0];
          REG_DURATION: dur_r      <= cfg_data;
          REG_HOLD:     hold_r     <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  assign in_stall      = (state_r != S_IDLE);
  assign cfg_ready     = 1'b1;
  assign out_valid     = out_valid_r;
  assign out_azimuth   = out_az_r;
  assign out_elevation = out_el_r;
  assign out_valid_res = out_v_res_r;

  // A finished multiply only arrives while the sequencer waits for one.
  `PTG_ASSERT_IMPL(a_mul_state, clk, rst_n, mul_done,
    state_r == S_MUL_AZ || state_r == S_MUL_IP || state_r == S_MUL_EL)
  // A finished divide only arrives in the divide state.
  `PTG_ASSERT_IMPL(a_div_state, clk, rst_n, div_done, state_r == S_DIV)
  // An inactive result carries either zero or the expiry elevation.
  `PTG_ASSERT_IMPL(a_inactive_el, clk, rst_n, out_valid && !out_valid_res,
    out_elevation == 15'sd0 || out_elevation == EXPIRED_EL)
  // A stalled result stays offered.
  `PTG_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)

endmodule

/* tb/pass_trajectory_generator_top_test.sv */
// Testbench for the pass trajectory generator: directed and random passes with
// a scoreboard that predicts every pointing result. Depends on ptg_pkg and the RTL.
module pass_trajectory_generator_top_test;
  import ptg_pkg::*;

  localparam logic       CMD_SAMPLE = 1'b0;
  localparam logic       CMD_START  = 1'b1;
  localparam logic [2:0] REG_SPARE  = 3'd7;
  localparam int         SETTLE     = 150;

  typedef struct {
    logic [15:0]        az;
    logic signed [14:0] el;
    logic               act;
  } pointing_t;

  // Predicts the pointing for each sample and holds the results still due.
  class pointing_scoreboard;
    bit [0:0]   en, looping;
    bit [15:0]  az_from, az_to, dur_reg, hold_reg;
    bit [13:0]  peak_reg;
    bit [31:0]  pass_start;
    bit         running;
    pointing_t  due[$];
    int         errors, results, samples, starts;
    longint     sin2[33];

    function new();
      sin2 = '{0, 158, 630, 1411, 2494, 3869, 5522, 7438, 9598, 11980, 14563,
               17321, 20228, 23256, 26376, 29556, 32768, 35980, 39160, 42280,
               45308, 48215, 50973, 53556, 55938, 58098, 60014, 61667, 63042,
               64125, 64906, 65378, 65536};
      en = 0; looping = 0; az_from = 0; az_to = 18000; peak_reg = 4500;
      dur_reg = 120; hold_reg = 0; pass_start = 0; running = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] data);
      case (idx)
        REG_ENABLE: begin
          en = data[0];
          if (!data[0]) running = 0;
        end
        REG_LOOP:     looping = data[0];
        REG_AZ_START: az_from = data;
        REG_AZ_END:   az_to = data;
        REG_PEAK:     peak_reg = data[13:0];
        REG_DURATION: dur_reg = data;
        REG_HOLD:     hold_reg = data;
        default: ;
      endcase
    endfunction

    function longint shape(longint t);
      longint tf, k, frac;
      tf = (t > 32768) ? 65536 - t : t;
      k = tf >> 10;
      frac = tf & 1023;
      if (k >= 32) return sin2[32];
      return sin2[k] + (((sin2[k+1] - sin2[k]) * frac) >> 10);
    endfunction

    function void push(longint az, longint el, bit act);
      pointing_t r;
      r.az = az[15:0];
      r.el = el[14:0];
      r.act = act;
      due.push_back(r);
    endfunction

    // Note an accepted input item and queue the pointing it causes.
    function void note_item(logic cmd, logic [31:0] now);
      longint a0, a1, pk, dur, lim, dt, t, d, mag, p, az, el;
      if (cmd == CMD_START) begin
        pass_start = now;
        running = 1;
        starts++;
        return;
      end
      samples++;
      if (!en) begin
        push(0, 0, 0);
        return;
      end
      if (!running) begin
        pass_start = now;
        running = 1;
      end
      a0 = az_from % 36000;
      a1 = az_to % 36000;
      pk = (peak_reg > 9000) ? 9000 : peak_reg;
      dur = (dur_reg < 10) ? 10 : dur_reg;
      lim = dur + hold_reg;
      dt = longint'(now) - longint'(pass_start);
      if (dt < 0) dt = 0;
      if (dt > lim) begin
        if (looping) begin
          pass_start = now;
          dt = 0;
        end else begin
          push(a1, -500, 0);
          return;
        end
      end
      t = (dt >= dur) ? 65536 : (dt << 16) / dur;
      d = a1 - a0;
      if (d > 18000) d -= 36000;
      if (d < -18000) d += 36000;
      mag = (d < 0) ? -d : d;
      p = (mag * t + 32768) >> 16;
      az = a0 + ((d < 0) ? -p : p);
      if (az < 0) az += 36000;
      if (az >= 36000) az -= 36000;
      el = (pk * shape(t) + 32768) >> 16;
      if (dt > dur) begin
        az = a1;
        el = 0;
      end
      push(az, el, 1);
    endfunction

    // Compare one accepted result with the oldest prediction.
    function void check_result(logic [15:0] az, logic signed [14:0] el, logic act);
      pointing_t r;
      results++;
      if (due.size() == 0) begin
        $display("%0t: unexpected result az=%0d el=%0d valid=%0b", $time, az, el, act);
        errors++;
        return;
      end
      r = due.pop_front();
      if (az !== r.az) begin
        $display("%0t: azimuth expected %0d, got %0d", $time, r.az, az);
        errors++;
      end
      if (el !== r.el) begin
        $display("%0t: elevation expected %0d, got %0d", $time, r.el, el);
        errors++;
      end
      if (act !== r.act) begin
        $display("%0t: valid_res expected %0b, got %0b", $time, r.act, act);
        errors++;
      end
    endfunction
  endclass

  logic               clk = 0;
  logic               rst_n = 0;
  logic               in_valid = 0;
  logic               in_stall;
  logic               in_cmd = 0;
  logic [31:0]        in_time_now = 0;
  logic               out_valid;
  logic               out_stall = 0;
  logic [15:0]        out_azimuth;
  logic signed [14:0] out_elevation;
  logic               out_valid_res;
  logic               cfg_valid = 0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = 0;
  logic [15:0]        cfg_data = 0;

  pointing_scoreboard sb = new();
  int burst_left = 0;
  int gap_max = 6;
  int cycle = 0;
  int stall_mode = 0;

  pass_trajectory_generator_top i_dut (.*);

  always #2 clk = ~clk;

  // Both channels are observed at the rising edge.
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (rst_n && in_valid && !in_stall) sb.note_item(in_cmd, in_time_now);
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_azimuth, out_elevation, out_valid_res);
  end

  // The receiver stalls on a pattern whose mode is redrawn at random at regular intervals.
  always @(negedge clk) begin
    if (cycle % 300 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall <= 0;
      1: out_stall <= ($urandom_range(0, 1) == 1);
      2: out_stall <= ($urandom_range(0, 9) != 0);
      default: out_stall <= ((cycle / 7) % 2 == 1);
    endcase
  end

  // Send one item; the sender works in bursts with gaps between them.
  task automatic send(logic cmd, logic [31:0] now);
    int gap;
    @(negedge clk);
    in_valid = 1;
    in_cmd = cmd;
    in_time_now = now;
    do @(posedge clk); while (in_stall);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      gap = $urandom_range(0, gap_max);
      if (gap > 0) begin
        @(negedge clk);
        in_valid = 0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  // Wait until every predicted result has arrived, then let the block settle.
  task automatic drain();
    @(negedge clk);
    in_valid = 0;
    while (sb.due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] data);
    @(negedge clk);
    cfg_valid = 1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_valid = 0;
  endtask

  function automatic logic [15:0] pick(logic [15:0] lo, logic [15:0] hi);
    case ($urandom_range(0, 5))
      0: return lo;
      1: return hi;
      2: return 16'($urandom());
      default: return 16'($urandom_range(lo, hi));
    endcase
  endfunction

  // One random pass: usually a start, then samples marching through and past the pass.
  task automatic run_pass();
    logic [31:0] base, now;
    longint span;
    int n;
    base = $urandom();
    span = ((sb.dur_reg < 10) ? 10 : sb.dur_reg) + sb.hold_reg;
    if ($urandom_range(0, 9) < 7) send(CMD_START, base);
    now = base;
    n = $urandom_range(4, 24);
    repeat (n) begin
      case ($urandom_range(0, 19))
        0: send(CMD_SAMPLE, $urandom());
        1: send(CMD_SAMPLE, base - $urandom_range(1, 50));
        2: send(CMD_START, now);
        default: begin
          now = now + $urandom_range(0, int'(span / 6) + 2);
          send(CMD_SAMPLE, now);
        end
      endcase
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // Disabled generator, start while disabled, then a pass with defaults.
    send(CMD_SAMPLE, 32'd5);
    send(CMD_START, 32'd100);
    drain();
    write_reg(REG_ENABLE, 16'd1);
    send(CMD_SAMPLE, 32'd99);
    send(CMD_SAMPLE, 32'd100);
    send(CMD_SAMPLE, 32'd160);
    send(CMD_SAMPLE, 32'd220);
    send(CMD_SAMPLE, 32'd221);
    send(CMD_SAMPLE, 32'hFFFF_FFFF);
    drain();
    write_reg(REG_LOOP, 16'd1);
    write_reg(REG_AZ_START, 16'd35999);
    write_reg(REG_AZ_END, 16'd0);
    write_reg(REG_PEAK, 16'h3FFF);
    send(CMD_SAMPLE, 32'hFFFF_FFFF);
    send(CMD_SAMPLE, 32'd0);
    send(CMD_SAMPLE, 32'h0000_003C);
    drain();
    write_reg(REG_ENABLE, 16'd0);
    write_reg(REG_ENABLE, 16'd1);
    write_reg(REG_DURATION, 16'd0);
    write_reg(REG_HOLD, 16'hFFFF);
    write_reg(REG_SPARE, 16'hFFFF);
    send(CMD_SAMPLE, 32'd0);
    send(CMD_SAMPLE, 32'd5);
    send(CMD_SAMPLE, 32'd10);
    send(CMD_SAMPLE, 32'd11);
    send(CMD_START, 32'hFFFF_FFFF);
    send(CMD_SAMPLE, 32'hFFFF_FFFE);
    send(CMD_SAMPLE, 32'hFFFF_FFFF);
    drain();

    // Random phases, each with a fresh register setting.
    for (int ph = 0; ph < 12; ph++) begin
      gap_max = (ph % 3 == 0) ? 0 : 6;
      write_reg(REG_ENABLE, ($urandom_range(0, 6) == 0) ? 16'd0 : 16'd1);
      write_reg(REG_LOOP, 16'($urandom_range(0, 1)));
      write_reg(REG_AZ_START, pick(16'd0, 16'd35999));
      write_reg(REG_AZ_END, pick(16'd0, 16'd35999));
      write_reg(REG_PEAK, pick(16'd0, 16'd9000));
      write_reg(REG_DURATION, ($urandom_range(0, 5) == 0) ? pick(16'd0, 16'hFFFF)
                                                           : 16'($urandom_range(0, 300)));
      write_reg(REG_HOLD, ($urandom_range(0, 5) == 0) ? pick(16'd0, 16'hFFFF)
                                                       : 16'($urandom_range(0, 40)));
      if (ph % 4 == 1) write_reg(REG_SPARE, 16'($urandom()));
      while (sb.samples + sb.starts < 65 * (ph + 1) + 10) run_pass();
      drain();
    end

    $display("Covered %0d start commands and %0d time samples; %0d results checked.",
             sb.starts, sb.samples, sb.results);
    if (sb.errors == 0 && sb.due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Timed out with %0d results still due.", sb.due.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/ptg_pkg.sv
rtl/ptg_mul.sv
rtl/ptg_div.sv
rtl/pass_trajectory_generator_top.sv
tb/pass_trajectory_generator_top_test.sv
